// ----- hw/rtl/gpvg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvg_pkg
// Shared types, constants and helpers of the grid plane vertex generator.
// ----------------------------------------------------------------------------
package gpvg_pkg;

  localparam int unsigned SEG_W        = 8;
  localparam int unsigned MAX_SEGMENTS = 255;
  localparam int unsigned NUM_W        = 24;
  localparam int unsigned QUOT_W       = 17;
  localparam int unsigned PIPE_DEPTH   = 7;
  localparam int unsigned LAST_STAGE   = PIPE_DEPTH - 1;
  localparam int unsigned DIV_DONE     = 3;

  typedef enum logic [2:0] {
    CFG_COLUMNS,
    CFG_ROWS,
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_CENTER,
    CFG_AXIS_U,
    CFG_AXIS_V
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] grid_column;
    logic [7:0] grid_row;
  } grid_word_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               has_cell;
    logic [15:0]        first_a;
    logic [15:0]        first_b;
    logic [15:0]        first_c;
    logic [15:0]        second_a;
    logic [15:0]        second_b;
    logic [15:0]        second_c;
  } vertex_word_t;

  typedef struct packed {
    logic [7:0]  columns_in_use;
    logic [7:0]  rows_in_use;
    logic [15:0] plane_width;
    logic [15:0] plane_height;
    logic [47:0] center_point;
    logic [47:0] axis_u_column;
    logic [47:0] axis_v_column;
  } cfg_t;

  typedef struct packed {
    logic [SEG_W-1:0]  col;
    logic              opens_cell;
    logic [16:0]       row1;
    logic [NUM_W-1:0]  num_x;
    logic [NUM_W-1:0]  num_y;
    logic [NUM_W-1:0]  num_tu;
    logic [NUM_W-1:0]  num_tv;
  } prep_t;

  typedef struct packed {
    logic        opens_cell;
    logic [15:0] idx_a;
    logic [15:0] idx_b;
    logic [15:0] idx_c;
    logic [15:0] idx_d;
  } side_t;

  function automatic logic [SEG_W-1:0] clamp_segs(input logic [SEG_W-1:0] segs);
    if ((SEG_W + 2)'(segs) > (SEG_W + 2)'(MAX_SEGMENTS)) begin
      return SEG_W'(MAX_SEGMENTS);
    end
    return segs;
  endfunction

endpackage

// ----- hw/rtl/gpvg_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvg_prep
// First stage: clamps the grid point and forms the dividends and row start.
// ----------------------------------------------------------------------------
module gpvg_prep (
  input  logic                     clk,
  input  logic                     en,
  input  gpvg_pkg::grid_word_t     grid_word,
  input  gpvg_pkg::cfg_t           cfg,
  input  logic [gpvg_pkg::SEG_W-1:0] segs_x,
  input  logic [gpvg_pkg::SEG_W-1:0] segs_y,
  output gpvg_pkg::prep_t          prep
);

  logic [gpvg_pkg::SEG_W-1:0] col;
  logic [gpvg_pkg::SEG_W-1:0] row;
  logic [gpvg_pkg::SEG_W-1:0] bias_x;
  logic [gpvg_pkg::SEG_W-1:0] bias_y;
  gpvg_pkg::prep_t            prep_next;

  // An odd length drops the half segment bias so that the local length
  // reduces to an unsigned quotient minus half the length.
  always_comb begin
    col    = (grid_word.grid_column > segs_x) ? segs_x : grid_word.grid_column;
    row    = (grid_word.grid_row > segs_y) ? segs_y : grid_word.grid_row;
    bias_x = cfg.plane_width[0] ? '0 : (segs_x >> 1);
    bias_y = cfg.plane_height[0] ? '0 : (segs_y >> 1);

    prep_next.col        = col;
    prep_next.opens_cell = (col < segs_x) && (row < segs_y);
    prep_next.row1       = 17'(row) * 17'({1'b0, segs_x} + 9'd1);
    prep_next.num_x      = 24'(col) * 24'(cfg.plane_width) + 24'(bias_x);
    prep_next.num_y      = 24'(row) * 24'(cfg.plane_height) + 24'(bias_y);
    prep_next.num_tu     = {col, 16'h0000} + 24'(segs_x >> 1);
    prep_next.num_tv     = {row, 16'h0000} + 24'(segs_y >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep <= prep_next;
    end
  end

endmodule

// ----- hw/rtl/gpvg_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvg_divider
// Three-stage restoring divider for a 24-bit dividend by an 8-bit divisor,
// valid when the quotient fits 17 bits. Six, six and five steps per stage.
// ----------------------------------------------------------------------------
module gpvg_divider (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  logic [gpvg_pkg::SEG_W-1:0]    divisor,
  input  logic [gpvg_pkg::NUM_W-1:0]    dividend,
  output logic [gpvg_pkg::QUOT_W-1:0]   quotient
);

  logic [7:0]  rem_a;
  logic [7:0]  rem_a_next;
  logic [5:0]  q_a;
  logic [5:0]  q_a_next;
  logic [10:0] low_a;
  logic [7:0]  rem_b;
  logic [7:0]  rem_b_next;
  logic [11:0] q_b;
  logic [5:0]  q_b_next;
  logic [4:0]  low_b;
  logic [7:0]  rem_c_next;
  logic [4:0]  q_c_next;

  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic bit_in,
                                          input logic [7:0] dvs);
    logic [8:0] trial;
    trial = {rem, bit_in};
    if (trial >= {1'b0, dvs}) begin
      return {1'b1, 8'(trial - {1'b0, dvs})};
    end
    return {1'b0, trial[7:0]};
  endfunction

  // The top seven dividend bits are already below the divisor.
  always_comb begin
    rem_a_next = {1'b0, dividend[23:17]};
    q_a_next   = '0;
    for (int i = 0; i < 6; i++) begin
      {q_a_next[5 - i], rem_a_next} = div_step(rem_a_next, dividend[16 - i], divisor);
    end
  end

  always_comb begin
    rem_b_next = rem_a;
    q_b_next   = '0;
    for (int i = 0; i < 6; i++) begin
      {q_b_next[5 - i], rem_b_next} = div_step(rem_b_next, low_a[10 - i], divisor);
    end
  end

  always_comb begin
    rem_c_next = rem_b;
    q_c_next   = '0;
    for (int i = 0; i < 5; i++) begin
      {q_c_next[4 - i], rem_c_next} = div_step(rem_c_next, low_b[4 - i], divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_a <= rem_a_next;
      q_a   <= q_a_next;
      low_a <= dividend[10:0];
    end
    if (en[1]) begin
      rem_b <= rem_b_next;
      q_b   <= {q_a, q_b_next};
      low_b <= low_a[4:0];
    end
    if (en[2]) begin
      quotient <= {q_b, q_c_next};
    end
  end

endmodule

// ----- hw/rtl/gpvg_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvg_transform
// Local coordinates, rotation products, rounding, centering and saturation,
// in three register stages.
// ----------------------------------------------------------------------------
module gpvg_transform (
  input  logic                         clk,
  input  logic [2:0]                   en,
  input  gpvg_pkg::cfg_t               cfg,
  input  logic [gpvg_pkg::QUOT_W-1:0]  quot_x,
  input  logic [gpvg_pkg::QUOT_W-1:0]  quot_y,
  output logic signed [15:0]           pos_x,
  output logic signed [15:0]           pos_y,
  output logic signed [15:0]           pos_z
);

  localparam logic signed [35:0] ROUND_BIAS = 36'sd8192;

  logic signed [17:0] lx;
  logic signed [17:0] ly;
  logic signed [33:0] prod_u [3];
  logic signed [33:0] prod_v [3];
  logic signed [35:0] acc    [3];
  logic signed [21:0] scaled [3];
  logic signed [22:0] wide   [3];
  logic signed [15:0] pos_next [3];
  logic signed [15:0] pos    [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lx <= $signed({1'b0, quot_x}) - $signed({3'b000, cfg.plane_width[15:1]});
      ly <= $signed({1'b0, quot_y}) - $signed({3'b000, cfg.plane_height[15:1]});
    end
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        prod_u[k] <= 34'($signed(cfg.axis_u_column[16 * k +: 16])) * 34'(lx);
        prod_v[k] <= 34'($signed(cfg.axis_v_column[16 * k +: 16])) * 34'(ly);
      end
    end
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        pos[k] <= pos_next[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k]    = 36'(prod_u[k]) + 36'(prod_v[k]) + ROUND_BIAS;
      scaled[k] = $signed(acc[k][35:14]);
      wide[k]   = 23'(scaled[k]) + 23'($signed(cfg.center_point[16 * k +: 16]));
      if (wide[k] > 23'sd32767) begin
        pos_next[k] = 16'sh7FFF;
      end else if (wide[k] < -23'sd32768) begin
        pos_next[k] = 16'sh8000;
      end else begin
        pos_next[k] = wide[k][15:0];
      end
    end
  end

  assign pos_x = pos[0];
  assign pos_y = pos[1];
  assign pos_z = pos[2];

endmodule

// ----- hw/rtl/grid_plane_vertex_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_plane_vertex_generator_top
// Turns one grid point of a tessellated plane into its world vertex, texture
// coordinates and the triangle indices of the cell it opens.
//
//   channel  flow  payload                 handshake
//   grid     in    gpvg_pkg::grid_word_t   grid_valid / grid_ready
//   vert     out   gpvg_pkg::vertex_word_t vert_valid / vert_ready
//   cfg      in    cfg_index, cfg_data     cfg_valid / cfg_ready
//
// One word is taken per cycle unless a stall holds the first stage. Each result
// passes the prep stage, the 17-step divider spread over three stages and the
// three-stage transform behind it.
// Reset clears all stage valid flags and loads the register defaults.
// A stage holds only while it is full and the stage after it holds, so
// bubbles fill during a stall. A word taken while either segment count is
// zero produces no result.
// ----------------------------------------------------------------------------
module grid_plane_vertex_generator_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    grid_valid,
  output logic                    grid_ready,
  input  gpvg_pkg::grid_word_t    grid_word,
  output logic                    vert_valid,
  input  logic                    vert_ready,
  output gpvg_pkg::vertex_word_t  vert_word,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [47:0]             cfg_data
);

  gpvg_pkg::cfg_t              cfg;
  logic [gpvg_pkg::SEG_W-1:0]  segs_x;
  logic [gpvg_pkg::SEG_W-1:0]  segs_y;
  logic [gpvg_pkg::PIPE_DEPTH-1:0] valid;
  logic [gpvg_pkg::PIPE_DEPTH-1:0] rdy;
  logic                        entry_valid;
  gpvg_pkg::prep_t             prep;
  gpvg_pkg::side_t             side_next;
  gpvg_pkg::side_t             side [1:gpvg_pkg::LAST_STAGE];
  logic [16:0]                 row_a;
  logic [16:0]                 row_c;
  logic [gpvg_pkg::QUOT_W-1:0] quot_x;
  logic [gpvg_pkg::QUOT_W-1:0] quot_y;
  logic [gpvg_pkg::QUOT_W-1:0] quot_tu;
  logic [gpvg_pkg::QUOT_W-1:0] quot_tv;
  logic [16:0]                 tex_u [gpvg_pkg::DIV_DONE+1:gpvg_pkg::LAST_STAGE];
  logic [16:0]                 tex_v [gpvg_pkg::DIV_DONE+1:gpvg_pkg::LAST_STAGE];
  logic signed [15:0]          pos_x;
  logic signed [15:0]          pos_y;
  logic signed [15:0]          pos_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns_in_use <= 8'd1;
      cfg.rows_in_use    <= 8'd1;
      cfg.plane_width    <= 16'd256;
      cfg.plane_height   <= 16'd256;
      cfg.center_point   <= 48'h0000_0000_0000;
      cfg.axis_u_column  <= 48'h0000_0000_4000;
      cfg.axis_v_column  <= 48'h0000_4000_0000;
    end else if (cfg_valid) begin
      unique case (gpvg_pkg::cfg_reg_t'(cfg_index))
        gpvg_pkg::CFG_COLUMNS: cfg.columns_in_use <= cfg_data[7:0];
        gpvg_pkg::CFG_ROWS:    cfg.rows_in_use    <= cfg_data[7:0];
        gpvg_pkg::CFG_WIDTH:   cfg.plane_width    <= cfg_data[15:0];
        gpvg_pkg::CFG_HEIGHT:  cfg.plane_height   <= cfg_data[15:0];
        gpvg_pkg::CFG_CENTER:  cfg.center_point   <= cfg_data;
        gpvg_pkg::CFG_AXIS_U:  cfg.axis_u_column  <= cfg_data;
        gpvg_pkg::CFG_AXIS_V:  cfg.axis_v_column  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign segs_x = gpvg_pkg::clamp_segs(cfg.columns_in_use);
  assign segs_y = gpvg_pkg::clamp_segs(cfg.rows_in_use);

  always_comb begin
    rdy[gpvg_pkg::LAST_STAGE] = !valid[gpvg_pkg::LAST_STAGE] || vert_ready;
    for (int i = gpvg_pkg::LAST_STAGE - 1; i >= 0; i--) begin
      rdy[i] = !valid[i] || rdy[i + 1];
    end
  end

  assign grid_ready  = rdy[0];
  assign entry_valid = grid_valid && (segs_x != '0) && (segs_y != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[0]) begin
        valid[0] <= entry_valid;
      end
      for (int i = 1; i < gpvg_pkg::PIPE_DEPTH; i++) begin
        if (rdy[i]) begin
          valid[i] <= valid[i - 1];
        end
      end
    end
  end

  gpvg_prep u_prep (
    .clk       (clk),
    .en        (rdy[0]),
    .grid_word (grid_word),
    .cfg       (cfg),
    .segs_x    (segs_x),
    .segs_y    (segs_y),
    .prep      (prep)
  );

  gpvg_divider u_div_x (
    .clk      (clk),
    .en       (rdy[3:1]),
    .divisor  (segs_x),
    .dividend (prep.num_x),
    .quotient (quot_x)
  );

  gpvg_divider u_div_y (
    .clk      (clk),
    .en       (rdy[3:1]),
    .divisor  (segs_y),
    .dividend (prep.num_y),
    .quotient (quot_y)
  );

  gpvg_divider u_div_tu (
    .clk      (clk),
    .en       (rdy[3:1]),
    .divisor  (segs_x),
    .dividend (prep.num_tu),
    .quotient (quot_tu)
  );

  gpvg_divider u_div_tv (
    .clk      (clk),
    .en       (rdy[3:1]),
    .divisor  (segs_y),
    .dividend (prep.num_tv),
    .quotient (quot_tv)
  );

  gpvg_transform u_transform (
    .clk    (clk),
    .en     (rdy[6:4]),
    .cfg    (cfg),
    .quot_x (quot_x),
    .quot_y (quot_y),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .pos_z  (pos_z)
  );

  // Indices wrap to 16 bits; a point that opens no cell carries zeros.
  always_comb begin
    row_a = prep.row1 + 17'(prep.col);
    row_c = prep.row1 + 17'(segs_x) + 17'd1 + 17'(prep.col);
    side_next.opens_cell = prep.opens_cell;
    side_next.idx_a = prep.opens_cell ? row_a[15:0] : '0;
    side_next.idx_b = prep.opens_cell ? 16'(row_a + 17'd1) : '0;
    side_next.idx_c = prep.opens_cell ? row_c[15:0] : '0;
    side_next.idx_d = prep.opens_cell ? 16'(row_c + 17'd1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side[1] <= side_next;
    end
    for (int i = 2; i <= gpvg_pkg::LAST_STAGE; i++) begin
      if (rdy[i]) begin
        side[i] <= side[i - 1];
      end
    end
    if (rdy[gpvg_pkg::DIV_DONE + 1]) begin
      tex_u[gpvg_pkg::DIV_DONE + 1] <= quot_tu;
      tex_v[gpvg_pkg::DIV_DONE + 1] <= quot_tv;
    end
    for (int i = gpvg_pkg::DIV_DONE + 2; i <= gpvg_pkg::LAST_STAGE; i++) begin
      if (rdy[i]) begin
        tex_u[i] <= tex_u[i - 1];
        tex_v[i] <= tex_v[i - 1];
      end
    end
  end

  assign vert_valid = valid[gpvg_pkg::LAST_STAGE];

  always_comb begin
    vert_word.pos_x    = pos_x;
    vert_word.pos_y    = pos_y;
    vert_word.pos_z    = pos_z;
    vert_word.tex_u    = tex_u[gpvg_pkg::LAST_STAGE];
    vert_word.tex_v    = tex_v[gpvg_pkg::LAST_STAGE];
    vert_word.has_cell = side[gpvg_pkg::LAST_STAGE].opens_cell;
    vert_word.first_a  = side[gpvg_pkg::LAST_STAGE].idx_a;
    vert_word.first_b  = side[gpvg_pkg::LAST_STAGE].idx_b;
    vert_word.first_c  = side[gpvg_pkg::LAST_STAGE].idx_c;
    vert_word.second_a = side[gpvg_pkg::LAST_STAGE].idx_c;
    vert_word.second_b = side[gpvg_pkg::LAST_STAGE].idx_b;
    vert_word.second_c = side[gpvg_pkg::LAST_STAGE].idx_d;
  end

endmodule

// ----- hw/rtl/gpvg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvg_checker
// Port-level checks of the vertex output, bound to the top level.
// ----------------------------------------------------------------------------
module gpvg_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   vert_valid,
  input logic                   vert_ready,
  input gpvg_pkg::vertex_word_t vert_word
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !vert_valid)
    else $error("Result word present right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vert_valid && !vert_ready |=> vert_valid && $stable(vert_word))
    else $error("Stalled result word changed or vanished.");

  a_no_cell_zero: assert property (@(posedge clk) disable iff (rst)
    vert_valid && !vert_word.has_cell |->
      vert_word.first_a == 16'd0 && vert_word.first_b == 16'd0 &&
      vert_word.first_c == 16'd0 && vert_word.second_a == 16'd0 &&
      vert_word.second_b == 16'd0 && vert_word.second_c == 16'd0)
    else $error("Indices not cleared for a point without a cell.");

  a_shared_idx: assert property (@(posedge clk) disable iff (rst)
    vert_valid |-> vert_word.first_b == vert_word.second_b &&
                   vert_word.first_c == vert_word.second_a)
    else $error("Shared triangle corners disagree.");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    vert_valid |-> vert_word.tex_u <= 17'h10000 && vert_word.tex_v <= 17'h10000)
    else $error("Texture coordinate above one.");

endmodule

bind grid_plane_vertex_generator_top gpvg_checker u_gpvg_checker (.*);
